@@ design/qrs_pkg.sv @@
// ---------------------------------------------------------------------------
// qrs_pkg: shared definitions for the quadratic root solver
// Result kind codes, fixed output width and default parameter values.
// ---------------------------------------------------------------------------
package qrs_pkg;

  localparam int OUT_BITS      = 40;
  localparam int COEF_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_REAL2   = 2'd1,
    KIND_DOUBLE  = 2'd2,
    KIND_COMPLEX = 2'd3
  } root_kind_t;

endpackage

@@ design/qrs_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of a restoring square root
// Takes the next two radicand bits, decides one root bit, hands on.
// ---------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int RB  = 17,
  parameter int SBW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RB-1:0]   in_rad,
  input  logic [RB+1:0]     in_rem,
  input  logic [RB-1:0]     in_root,
  input  logic [SBW-1:0]    in_sb,
  output logic              out_valid,
  output logic [2*RB-1:0]   out_rad,
  output logic [RB+1:0]     out_rem,
  output logic [RB-1:0]     out_root,
  output logic [SBW-1:0]    out_sb
);

  logic [RB+1:0] rem_sh;
  logic [RB+1:0] trial;
  logic          ge;

  always_comb begin
    rem_sh = {in_rem[RB-1:0], in_rad[2*RB-1 -: 2]};
    trial  = {in_root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= in_rad << 2;
      out_rem  <= ge ? (rem_sh - trial) : rem_sh;
      out_root <= {in_root[RB-2:0], ge};
      out_sb   <= in_sb;
    end
  end

endmodule

@@ design/qrs_div_cell.sv @@
// ---------------------------------------------------------------------------
// qrs_div_cell: one quotient bit of two restoring divisions
// Both lanes share the divisor; the numerator register collects the quotient.
// ---------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int NM  = 34,
  parameter int DB  = 17,
  parameter int SBW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DB-1:0]     in_den,
  input  logic [NM-1:0]     in_num1,
  input  logic [DB:0]       in_rem1,
  input  logic [NM-1:0]     in_num2,
  input  logic [DB:0]       in_rem2,
  input  logic [SBW-1:0]    in_sb,
  output logic              out_valid,
  output logic [DB-1:0]     out_den,
  output logic [NM-1:0]     out_num1,
  output logic [DB:0]       out_rem1,
  output logic [NM-1:0]     out_num2,
  output logic [DB:0]       out_rem2,
  output logic [SBW-1:0]    out_sb
);

  logic [DB:0] sh1;
  logic [DB:0] sh2;
  logic [DB:0] den_x;
  logic        ge1;
  logic        ge2;

  always_comb begin
    den_x = {1'b0, in_den};
    sh1   = {in_rem1[DB-1:0], in_num1[NM-1]};
    sh2   = {in_rem2[DB-1:0], in_num2[NM-1]};
    ge1   = (sh1 >= den_x);
    ge2   = (sh2 >= den_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_den  <= in_den;
      out_rem1 <= ge1 ? (sh1 - den_x) : sh1;
      out_rem2 <= ge2 ? (sh2 - den_x) : sh2;
      out_num1 <= {in_num1[NM-2:0], ge1};
      out_num2 <= {in_num2[NM-2:0], ge2};
      out_sb   <= in_sb;
    end
  end

endmodule

@@ design/quadratic_root_solver.sv @@
// ---------------------------------------------------------------------------
// quadratic_root_solver: roots of a*x^2 + b*x + c, fully pipelined
// Coefficient triples in, kind plus two signed fixed point values out.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one coefficient triple per beat (a, b, c from the
//   low bits up). Master stream returns one beat per triple: tuser holds the
//   root kind, tdata holds value_one then value_two, each signed with
//   FRAC_BITS fraction bits in a 40-bit field.
//   The square root chain yields one root bit per cell and the divider
//   chain one quotient bit per cell; every cell takes a new triple each
//   cycle while the output is not stalled, so throughput is one beat per
//   cycle. Results leave in input order.
//   Reset clears every stage valid bit; no triple is in flight afterwards.
//   When the receiver holds tready low with a result waiting, the whole
//   pipeline holds in place and s_tready drops in the same cycle; it rises
//   again in the cycle the waiting beat is taken.
// ---------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // coef_a, coef_b, coef_c from bit 0 up, zero filled to bytes
  input  logic [((3*COEF_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // value_one [39:0], value_two [79:40]
  output logic [2*qrs_pkg::OUT_BITS-1:0]       m_tdata,
  // root_kind [1:0]
  output logic [1:0]                           m_tuser
);

  import qrs_pkg::*;

  localparam int N   = COEF_BITS;
  localparam int PW  = 2 * N;          // product width
  localparam int DW  = 2 * N + 3;      // discriminant width
  localparam int RB  = N + 1;          // root bits
  localparam int SW  = 2 * RB;         // radicand width
  localparam int NW  = N + 3;          // signed numerator width
  localparam int MW  = N + 2;          // numerator magnitude width
  localparam int NM  = MW + FRAC_BITS; // scaled numerator width
  localparam int DB  = N + 1;          // divisor width
  localparam int QX  = (NM > OUT_BITS) ? NM + 1 : OUT_BITS + 1;
  localparam int SBS = 2 + 2 * N;      // kind, a, b through the root chain
  localparam int SBD = 4;              // kind, two signs through the divider

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 0: capture the triple
  logic                v0;
  logic signed [N-1:0] a0, b0, c0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= s_tdata[N-1:0];
      b0 <= s_tdata[2*N-1:N];
      c0 <= s_tdata[3*N-1:2*N];
    end
  end

  // Stage 1: b*b and a*c
  logic                 v1;
  logic signed [PW-1:0] bsq1, ac1;
  logic signed [N-1:0]  a1, b1;

  // Stage 2: discriminant b*b - 4ac at full width
  logic                 v2;
  logic signed [DW-1:0] d2;
  logic signed [N-1:0]  a2, b2;

  // Stage 3: kind and |D|
  logic                 v3;
  root_kind_t           kind3;
  logic [DW-1:0]        dabs;
  logic [SW-1:0]        rad3;
  logic signed [N-1:0]  a3, b3;

  assign dabs = d2[DW-1] ? (~d2 + DW'(1)) : d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bsq1 <= b0 * b0;
      ac1  <= a0 * c0;
      a1   <= a0;
      b1   <= b0;
      d2   <= $signed({{3{bsq1[PW-1]}}, bsq1}) - $signed({ac1[PW-1], ac1, 2'b00});
      a2   <= a1;
      b2   <= b1;
      rad3 <= dabs[SW-1:0];
      a3   <= a2;
      b3   <= b2;
      if (a2 == '0) begin
        kind3 <= KIND_NONE;
      end else if (d2 == '0) begin
        kind3 <= KIND_DOUBLE;
      end else if (d2[DW-1]) begin
        kind3 <= KIND_COMPLEX;
      end else begin
        kind3 <= KIND_REAL2;
      end
    end
  end

  // Square root chain: one root bit per cell, most significant first
  logic [RB:0]           sq_v;
  logic [RB:0][SW-1:0]   sq_rad;
  logic [RB:0][RB+1:0]   sq_rem;
  logic [RB:0][RB-1:0]   sq_root;
  logic [RB:0][SBS-1:0]  sq_sb;

  assign sq_v[0]    = v3;
  assign sq_rad[0]  = rad3;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = {kind3, a3, b3};

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    qrs_sqrt_cell #(.RB(RB), .SBW(SBS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (sq_v[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_sb    (sq_sb[i]),
      .out_valid(sq_v[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_sb   (sq_sb[i+1])
    );
  end

  // Stage 4: signed numerators
  root_kind_t           kind_r;
  logic signed [N-1:0]  a_r, b_r;
  logic signed [NW-1:0] nb, r_ext;

  assign kind_r = root_kind_t'(sq_sb[RB][SBS-1 -: 2]);
  assign a_r    = sq_sb[RB][2*N-1:N];
  assign b_r    = sq_sb[RB][N-1:0];
  assign nb     = -$signed({{3{b_r[N-1]}}, b_r});
  assign r_ext  = $signed({2'b00, sq_root[RB]});

  logic                 v4;
  root_kind_t           kind4;
  logic signed [N-1:0]  a4;
  logic signed [NW-1:0] n1_4, n2_4;

  // Stage 5: magnitudes, result signs, divisor |2a|
  logic                 v5;
  logic [NM-1:0]        num1_5, num2_5;
  logic [DB-1:0]        den5;
  logic [SBD-1:0]       sb5;
  logic [NW-1:0]        m1, m2;
  logic [N-1:0]         a_abs;

  assign m1    = n1_4[NW-1] ? (~n1_4 + NW'(1)) : n1_4;
  assign m2    = n2_4[NW-1] ? (~n2_4 + NW'(1)) : n2_4;
  assign a_abs = a4[N-1] ? (~a4 + N'(1)) : a4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= sq_v[RB];
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind4 <= kind_r;
      a4    <= a_r;
      n1_4  <= (kind_r == KIND_REAL2) ? (nb + r_ext) : nb;
      case (kind_r)
        KIND_REAL2:   n2_4 <= nb - r_ext;
        KIND_COMPLEX: n2_4 <= r_ext;
        default:      n2_4 <= nb;
      endcase
      num1_5 <= NM'(m1[MW-1:0]) << FRAC_BITS;
      num2_5 <= NM'(m2[MW-1:0]) << FRAC_BITS;
      den5   <= {a_abs, 1'b0};
      // imaginary part divides by |2a|: always non-negative
      sb5    <= {kind4, n1_4[NW-1] ^ a4[N-1],
                 (kind4 == KIND_COMPLEX) ? 1'b0 : (n2_4[NW-1] ^ a4[N-1])};
    end
  end

  // Divider chain: one quotient bit per cell for both values
  logic [NM:0]           dv_v;
  logic [NM:0][DB-1:0]   dv_den;
  logic [NM:0][NM-1:0]   dv_num1, dv_num2;
  logic [NM:0][DB:0]     dv_rem1, dv_rem2;
  logic [NM:0][SBD-1:0]  dv_sb;

  assign dv_v[0]    = v5;
  assign dv_den[0]  = den5;
  assign dv_num1[0] = num1_5;
  assign dv_num2[0] = num2_5;
  assign dv_rem1[0] = '0;
  assign dv_rem2[0] = '0;
  assign dv_sb[0]   = sb5;

  for (genvar j = 0; j < NM; j++) begin : g_div
    qrs_div_cell #(.NM(NM), .DB(DB), .SBW(SBD)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv_v[j]),
      .in_den   (dv_den[j]),
      .in_num1  (dv_num1[j]),
      .in_rem1  (dv_rem1[j]),
      .in_num2  (dv_num2[j]),
      .in_rem2  (dv_rem2[j]),
      .in_sb    (dv_sb[j]),
      .out_valid(dv_v[j+1]),
      .out_den  (dv_den[j+1]),
      .out_num1 (dv_num1[j+1]),
      .out_rem1 (dv_rem1[j+1]),
      .out_num2 (dv_num2[j+1]),
      .out_rem2 (dv_rem2[j+1]),
      .out_sb   (dv_sb[j+1])
    );
  end

  // Apply sign and clamp to the signed 40-bit range
  function automatic logic [OUT_BITS-1:0] sign_sat(input logic [NM-1:0] q, input logic neg);
    logic [QX-1:0]       qx;
    logic [QX-1:0]       pos_max;
    logic [QX-1:0]       neg_max;
    logic [OUT_BITS-1:0] mag;
    qx      = QX'(q);
    pos_max = (QX'(1) << (OUT_BITS - 1)) - QX'(1);
    neg_max = QX'(1) << (OUT_BITS - 1);
    if (neg) begin
      mag      = (qx > neg_max) ? neg_max[OUT_BITS-1:0] : qx[OUT_BITS-1:0];
      sign_sat = ~mag + OUT_BITS'(1);
    end else begin
      sign_sat = (qx > pos_max) ? pos_max[OUT_BITS-1:0] : qx[OUT_BITS-1:0];
    end
  endfunction

  root_kind_t kind_f;
  assign kind_f = root_kind_t'(dv_sb[NM][3:2]);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_v[NM];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= kind_f;
      if (kind_f == KIND_NONE) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {sign_sat(dv_num2[NM], dv_sb[NM][0]),
                    sign_sat(dv_num1[NM], dv_sb[NM][1])};
      end
    end
  end

  // Checks
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_NONE) |-> (m_tdata == '0))
    else $error("not quadratic result carries nonzero values");

  a_double_eq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_DOUBLE) |->
      (m_tdata[OUT_BITS-1:0] == m_tdata[2*OUT_BITS-1:OUT_BITS]))
    else $error("double root values differ");

  a_imag_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_COMPLEX) |-> !m_tdata[2*OUT_BITS-1])
    else $error("imaginary magnitude negative");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_sb[NM]) && $stable(dv_v[NM]))
    else $error("pipeline moved while output stalled");

endmodule
